/* sv/swbm_pkg.sv */
// Types, codes and constants shared by the single-wire bus master.
package swbm_pkg;

	// Default depth of the byte buffer
	localparam int BUFFER_DEPTH_DEF = 16;

	// Item operation codes
	localparam logic [2:0] OP_WRITE = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_TICK  = 3'd2;
	localparam logic [2:0] OP_RISE  = 3'd3;
	localparam logic [2:0] OP_FALL  = 3'd4;

	// Bus phase
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_TX   = 2'd1;
	localparam logic [1:0] PH_RX   = 2'd2;

	// Completion status
	localparam logic [2:0] ST_NONE     = 3'd0;
	localparam logic [2:0] ST_TX_FAULT = 3'd1;
	localparam logic [2:0] ST_NO_PRES  = 3'd2;
	localparam logic [2:0] ST_RX_ERR   = 3'd3;
	localparam logic [2:0] ST_RX_DONE  = 3'd4;

	// Timer reload requests
	localparam logic [2:0] TA_NONE       = 3'd0;
	localparam logic [2:0] TA_NEXT_BIT   = 3'd1;
	localparam logic [2:0] TA_RX_START   = 3'd2;
	localparam logic [2:0] TA_RX_TIMEOUT = 3'd3;
	localparam logic [2:0] TA_RX_RESTART = 3'd4;
	localparam logic [2:0] TA_STOP       = 3'd5;

	// Configuration register indexes
	localparam logic [1:0] CFG_WIDTH_MIN = 2'd0;
	localparam logic [1:0] CFG_WIDTH_MID = 2'd1;
	localparam logic [1:0] CFG_WIDTH_MAX = 2'd2;
	localparam logic [1:0] CFG_PREAMBLE  = 2'd3;

	// Frame lengths in bit periods
	localparam logic [3:0] CMD_BITS  = 4'd13;
	localparam logic [3:0] BYTE_BITS = 4'd9;
	localparam logic [4:0] SLOT_MAX  = 5'd31;

	typedef struct packed {
		logic [2:0]  op;
		logic        bus_level;
		logic [15:0] pulse_width;
		logic [3:0]  write_index;
		logic [7:0]  write_byte;
		logic [15:0] command_word;
		logic [4:0]  send_count;
		logic [4:0]  receive_count;
	} item_t;

	typedef struct packed {
		logic       bus_drive;
		logic [1:0] mode;
		logic [2:0] status;
		logic [2:0] timer_action;
		logic [7:0] rx_byte;
		logic       rx_byte_valid;
		logic [3:0] rx_slot;
	} result_t;

endpackage

/* sv/single_wire_bus_master.sv */
// Single-wire bus master: event-driven transmit and receive sequencer with byte buffer.
//
// Usage: each item on the item channel is one event: a buffer byte write, a transfer
// start, a bit-timer tick (with the sampled line level) or a line edge (falling, or
// rising with the measured pulse width). Every accepted item yields exactly one result
// word carrying the driven level, the mode, the completion status, a timer reload
// request and, on a stored receive byte, the byte and its buffer slot.
// The result word is registered and appears in the cycle after acceptance. Throughput is
// one item per cycle unless stalled. The byte buffer is a synchronous memory whose
// registered read port is always pre-addressed at the next slot, with a bypass when
// the same slot is written in that cycle, so the transmit path never waits on it.
// The result register parts the two channels: while it holds a word that the receiver
// stalls, item_stall is raised and nothing is lost or repeated.
// Configuration (pulse width thresholds, preamble length) is written on the cfg channel,
// always ready; the user writes it only while the master is idle, the block does not check.
// Reset (arst_n low) returns to idle, drive low, all thresholds to their defaults;
// buffer contents are undefined until written.
module single_wire_bus_master #(
	parameter int BUFFER_DEPTH = swbm_pkg::BUFFER_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  swbm_pkg::item_t  item,
	output logic             result_valid,
	input  logic             result_stall,
	output swbm_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data
);
	import swbm_pkg::*;

	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

	// configuration
	logic [15:0] width_min_q, width_mid_q, width_max_q;
	logic [3:0]  preamble_q;

	// control state
	logic [1:0]  phase_q, phase_d;
	logic        drive_q, drive_d;
	logic [3:0]  pre_cnt_q, pre_cnt_d;
	logic [3:0]  bit_cnt_q, bit_cnt_d;
	logic [15:0] shift_q, shift_d;
	logic [4:0]  slot_q, slot_d;
	logic        cmd_sent_q, cmd_sent_d;
	logic        bit_val_q, bit_val_d;
	logic        send_done_q, send_done_d;
	logic        wait_rise_q, wait_rise_d;
	logic [4:0]  tx_total_q, tx_total_d;
	logic [4:0]  rx_total_q, rx_total_d;
	logic [15:0] cmd_q, cmd_d;

	// buffer memory and its ports
	logic [7:0]    mem [BUFFER_DEPTH];
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data_q;
	logic          rd_oob_q;
	logic [AW+4:0] rd_wide;
	logic [AW+4:0] slot_wide;
	logic [AW+3:0] widx_wide;
	logic [7:0]    tx_byte;

	logic    accept;
	logic    res_valid_q;
	result_t res_d, res_q;
	logic    bit_in;

	assign accept     = item_valid && !item_stall;
	assign item_stall = res_valid_q && result_stall;
	assign cfg_ready  = 1'b1;

	assign rd_wide   = {{AW{1'b0}}, slot_d};
	assign rd_addr   = rd_wide[AW-1:0];
	assign slot_wide = {{AW{1'b0}}, slot_q};
	assign widx_wide = {{AW{1'b0}}, item.write_index};
	assign tx_byte   = rd_oob_q ? 8'd0 : rd_data_q;
	assign bit_in    = (item.pulse_width >= width_mid_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_min_q <= 16'd0;
			width_mid_q <= 16'd0;
			width_max_q <= 16'hFFFF;
			preamble_q  <= 4'd5;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WIDTH_MIN: width_min_q <= cfg_data;
				CFG_WIDTH_MID: width_mid_q <= cfg_data;
				CFG_WIDTH_MAX: width_max_q <= cfg_data;
				CFG_PREAMBLE:  preamble_q  <= cfg_data[3:0];
			endcase
		end
	end

	// next state and result word for one event
	always_comb begin
		phase_d     = phase_q;
		drive_d     = drive_q;
		pre_cnt_d   = pre_cnt_q;
		bit_cnt_d   = bit_cnt_q;
		shift_d     = shift_q;
		slot_d      = slot_q;
		cmd_sent_d  = cmd_sent_q;
		bit_val_d   = bit_val_q;
		send_done_d = send_done_q;
		wait_rise_d = wait_rise_q;
		tx_total_d  = tx_total_q;
		rx_total_d  = rx_total_q;
		cmd_d       = cmd_q;
		wr_en       = 1'b0;
		wr_addr     = widx_wide[AW-1:0];
		wr_data     = item.write_byte;
		res_d       = '0;

		if (accept) begin
			unique case (item.op)
				OP_WRITE: begin
					if (32'(item.write_index) < 32'(BUFFER_DEPTH))
						wr_en = 1'b1;
				end
				OP_START: begin
					if (phase_q == PH_IDLE) begin
						cmd_d       = item.command_word;
						tx_total_d  = (32'(item.send_count) > 32'(BUFFER_DEPTH)) ?
							5'(BUFFER_DEPTH) : item.send_count;
						rx_total_d  = (32'(item.receive_count) > 32'(BUFFER_DEPTH)) ?
							5'(BUFFER_DEPTH) : item.receive_count;
						phase_d     = PH_TX;
						drive_d     = 1'b0;
						pre_cnt_d   = 4'd0;
						bit_cnt_d   = 4'd0;
						slot_d      = 5'd0;
						cmd_sent_d  = 1'b0;
						bit_val_d   = 1'b0;
						send_done_d = 1'b0;
						wait_rise_d = 1'b0;
						res_d.timer_action = TA_NEXT_BIT;
					end
				end
				OP_TICK: begin
					if (phase_q == PH_TX) begin
						if (drive_q) begin
							// high part of a bit: short circuit check, then preamble or bit end
							if (item.bus_level) begin
								phase_d = PH_IDLE;
								drive_d = 1'b0;
								res_d.status = ST_TX_FAULT;
								res_d.timer_action = TA_STOP;
							end else begin
								if (pre_cnt_q < preamble_q)
									pre_cnt_d = pre_cnt_q + 4'd1;
								else begin
									if (!bit_val_q)
										drive_d = 1'b0;
									bit_val_d = 1'b0;
								end
								res_d.timer_action = TA_NEXT_BIT;
							end
						end else if ((bit_cnt_q >= CMD_BITS) && item.bus_level) begin
							// presence slot left high
							phase_d = PH_IDLE;
							drive_d = 1'b0;
							res_d.status = ST_NO_PRES;
							res_d.timer_action = TA_STOP;
						end else if ((bit_cnt_q < CMD_BITS) && !item.bus_level) begin
							// line missing
							phase_d = PH_IDLE;
							drive_d = 1'b0;
							res_d.status = ST_TX_FAULT;
							res_d.timer_action = TA_STOP;
						end else if (send_done_q) begin
							drive_d     = 1'b0;
							phase_d     = PH_RX;
							slot_d      = 5'd0;
							bit_cnt_d   = 4'd0;
							wait_rise_d = 1'b0;
							res_d.timer_action = TA_RX_START;
						end else begin
							drive_d = 1'b1;
							res_d.timer_action = TA_NEXT_BIT;
							if (pre_cnt_q == 4'd0) begin
								bit_val_d  = 1'b0;
								cmd_sent_d = 1'b0;
								bit_cnt_d  = 4'd0;
								slot_d     = 5'd0;
							end else if (!cmd_sent_q) begin
								// command frame
								if (bit_cnt_q == 4'd0) begin
									shift_d   = cmd_q;
									bit_val_d = 1'b0;
									bit_cnt_d = bit_cnt_q + 4'd1;
								end else if (bit_cnt_q >= CMD_BITS) begin
									bit_cnt_d  = 4'd0;
									bit_val_d  = 1'b1;
									cmd_sent_d = 1'b1;
									if (slot_q >= tx_total_q)
										send_done_d = 1'b1;
								end else begin
									bit_val_d = shift_q[15];
									shift_d   = {shift_q[14:0], 1'b0};
									bit_cnt_d = bit_cnt_q + 4'd1;
								end
							end else begin
								// byte frame from the buffer
								if (bit_cnt_q == 4'd0) begin
									shift_d   = {8'd0, tx_byte};
									if (slot_q < SLOT_MAX)
										slot_d = slot_q + 5'd1;
									bit_val_d = 1'b0;
									bit_cnt_d = bit_cnt_q + 4'd1;
								end else if (bit_cnt_q >= BYTE_BITS) begin
									bit_cnt_d = 4'd0;
									bit_val_d = 1'b1;
									if (slot_q >= tx_total_q)
										send_done_d = 1'b1;
								end else begin
									bit_val_d = shift_q[7];
									shift_d   = {shift_q[14:0], 1'b0};
									bit_cnt_d = bit_cnt_q + 4'd1;
								end
							end
						end
					end else if (phase_q == PH_RX) begin
						// receive timeout
						phase_d = PH_IDLE;
						drive_d = 1'b0;
						res_d.status = ST_RX_ERR;
						res_d.timer_action = TA_STOP;
					end
				end
				OP_RISE: begin
					if ((phase_q == PH_RX) && wait_rise_q) begin
						wait_rise_d = 1'b0;
						res_d.timer_action = TA_RX_TIMEOUT;
						if ((item.pulse_width >= width_max_q) ||
							(item.pulse_width <= width_min_q)) begin
							phase_d = PH_IDLE;
							drive_d = 1'b0;
							res_d.status = ST_RX_ERR;
							res_d.timer_action = TA_STOP;
						end else begin
							bit_val_d = bit_in;
							if (bit_cnt_q == 4'd0) begin
								// start bit must decode as zero
								if (bit_in) begin
									phase_d = PH_IDLE;
									drive_d = 1'b0;
									res_d.status = ST_RX_ERR;
									res_d.timer_action = TA_STOP;
								end else begin
									shift_d   = 16'd0;
									bit_cnt_d = bit_cnt_q + 4'd1;
								end
							end else if (bit_cnt_q >= BYTE_BITS) begin
								// stop bit must decode as one
								if (!bit_in) begin
									phase_d = PH_IDLE;
									drive_d = 1'b0;
									res_d.status = ST_RX_ERR;
									res_d.timer_action = TA_STOP;
								end else if (rx_total_q == 5'd0) begin
									phase_d = PH_IDLE;
									drive_d = 1'b0;
									res_d.status = ST_RX_DONE;
									res_d.timer_action = TA_STOP;
								end else begin
									if (32'(slot_q) < 32'(BUFFER_DEPTH)) begin
										wr_en   = 1'b1;
										wr_addr = slot_wide[AW-1:0];
										wr_data = shift_q[7:0];
										res_d.rx_byte       = shift_q[7:0];
										res_d.rx_byte_valid = 1'b1;
										res_d.rx_slot       = slot_q[3:0];
									end
									if (slot_q < SLOT_MAX)
										slot_d = slot_q + 5'd1;
									bit_cnt_d = 4'd0;
									if (((slot_q < SLOT_MAX) ? slot_q + 5'd1 : slot_q) >= rx_total_q) begin
										phase_d = PH_IDLE;
										drive_d = 1'b0;
										res_d.status = ST_RX_DONE;
										res_d.timer_action = TA_STOP;
									end
								end
							end else begin
								shift_d   = {8'd0, shift_q[6:0], bit_in};
								bit_cnt_d = bit_cnt_q + 4'd1;
							end
						end
					end
				end
				OP_FALL: begin
					if ((phase_q == PH_RX) && !wait_rise_q) begin
						wait_rise_d = 1'b1;
						res_d.timer_action = TA_RX_RESTART;
					end
				end
				default: begin
				end
			endcase
		end

		res_d.bus_drive = drive_d;
		res_d.mode      = phase_d;
	end

	// control state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			drive_q     <= 1'b0;
			pre_cnt_q   <= 4'd0;
			bit_cnt_q   <= 4'd0;
			shift_q     <= 16'd0;
			slot_q      <= 5'd0;
			cmd_sent_q  <= 1'b0;
			bit_val_q   <= 1'b0;
			send_done_q <= 1'b0;
			wait_rise_q <= 1'b0;
			tx_total_q  <= 5'd0;
			rx_total_q  <= 5'd0;
			cmd_q       <= 16'd0;
		end else begin
			phase_q     <= phase_d;
			drive_q     <= drive_d;
			pre_cnt_q   <= pre_cnt_d;
			bit_cnt_q   <= bit_cnt_d;
			shift_q     <= shift_d;
			slot_q      <= slot_d;
			cmd_sent_q  <= cmd_sent_d;
			bit_val_q   <= bit_val_d;
			send_done_q <= send_done_d;
			wait_rise_q <= wait_rise_d;
			tx_total_q  <= tx_total_d;
			rx_total_q  <= rx_total_d;
			cmd_q       <= cmd_d;
		end
	end

	// buffer write port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// buffer read port, addressed at the next slot, bypassing a same-slot write
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr))
			rd_data_q <= wr_data;
		else
			rd_data_q <= mem[rd_addr];
		rd_oob_q <= (32'(slot_d) >= 32'(BUFFER_DEPTH));
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (accept)
			res_valid_q <= 1'b1;
		else if (!result_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			res_q <= res_d;
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// checks
	a_idle_undriven: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> !drive_q)
		else $error("drive high while idle");

	a_rx_undriven: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RX) |-> !drive_q)
		else $error("drive high while receiving");

	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result_valid)
		else $error("accepted word gave no result");

	a_status_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.status != ST_NONE)) |-> (result.timer_action == TA_STOP))
		else $error("completion status without timer stop");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> ($stable(slot_q) && $stable(phase_q) && $stable(bit_cnt_q)))
		else $error("state moved without an accepted word");

endmodule
